@@ design/utf8_text_cursor_defines.svh @@
// Assertion macros shared by the utf8_text_cursor design files.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef UTF8_TEXT_CURSOR_DEFINES_SVH
`define UTF8_TEXT_CURSOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define UTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/utc_pkg.sv @@
// Shared types and constants of the UTF-8 text cursor block.
// Depends on nothing; used by the interfaces and every module.
package utc_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GlyphW = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // Commands of the input channel.
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // Kinds of result.
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DISP_WIDTH   = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_WIDTH  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_HEIGHT = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRAP_ENABLE  = 8'd3;

  // Register values after reset.
  localparam logic [CoordW-1:0] DISP_WIDTH_RST   = 16'd640;
  localparam logic [GlyphW-1:0] GLYPH_WIDTH_RST  = 8'd8;
  localparam logic [GlyphW-1:0] GLYPH_HEIGHT_RST = 8'd16;
  localparam logic              WRAP_ENABLE_RST  = 1'b1;

  localparam logic [CodeW-1:0] SPACE_CP = 21'h000020;

  typedef struct packed {
    logic [CoordW-1:0] disp_width;
    logic [GlyphW-1:0] glyph_width;
    logic [GlyphW-1:0] glyph_height;
    logic              wrap_enable;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [ByteW-1:0]  text_byte;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [CodeW-1:0]  code_point;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
  } res_item_t;

  typedef struct packed {
    logic      valid;
    res_item_t item;
  } res_push_t;

endpackage

@@ design/utc_ifs.sv @@
// Channel interfaces of the UTF-8 text cursor: input, result and configuration.
// Depends on utc_pkg for the field widths.
interface utc_in_if import utc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CoordW-1:0] start_x;
  logic [CoordW-1:0] start_y;
  logic [ByteW-1:0]  text_byte;

  modport source (output valid, command, start_x, start_y, text_byte, input ready);
  modport sink   (input valid, command, start_x, start_y, text_byte, output ready);
endinterface

interface utc_out_if import utc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CodeW-1:0]  code_point;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;

  modport source (output valid, kind, code_point, pos_x, pos_y, input ready);
  modport sink   (input valid, kind, code_point, pos_x, pos_y, output ready);
endinterface

interface utc_cfg_if import utc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/utf8_text_cursor.sv @@
// Top level of the UTF-8 text cursor: configuration registers, decoder and result buffer.
// Depends on utc_pkg, the channel interfaces, utc_core, utc_out_buf and the defines header.
//
// Use: send a begin request (command 0) carrying the string origin, then one request
// per text byte (command 1). Every completed UTF-8 sequence yields one result with the
// code point and the glyph's top-left position; a zero byte yields an end report with
// the cursor position. Begin requests, lead bytes and dropped bytes yield no result.
// Each result is registered into the output register, or into the skid register while
// that is held. Throughput: one request per cycle while the skid register is free, set
// by the single decode and cursor-update step between input handshake and output register.
// Stalls: results sit in a two-entry buffer (output register and skid register); the
// input keeps being taken while one result waits, and in_ch.ready drops only when both
// entries are full. Nothing is lost or repeated under back-pressure.
// Configuration: cfg_ch is always ready; writes take effect on the next request. The user's
// writes must be made while the block is idle (not enforced). Other indexes are ignored.
// Reset (rst_n low, synchronous): registers return to 640/8/16/wrap on, the cursor and
// origin go to 0,0, any partial sequence is cleared and the result buffer empties.
`include "utf8_text_cursor_defines.svh"

module utf8_text_cursor import utc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  utc_in_if.sink    in_ch,
  utc_out_if.source out_ch,
  utc_cfg_if.sink   cfg_ch
);

  cfg_t      cfg_r, cfg_nxt;
  in_item_t  req;
  res_push_t push;
  res_item_t out_item;
  logic      room;
  logic      fire;
  logic      end_out;
  logic      idle_begin;

  // Configuration writes never stall.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DISP_WIDTH:   cfg_nxt.disp_width   = cfg_ch.data;
        CFG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_ch.data[GlyphW-1:0];
        CFG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_ch.data[GlyphW-1:0];
        CFG_WRAP_ENABLE:  cfg_nxt.wrap_enable  = cfg_ch.data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.disp_width   <= DISP_WIDTH_RST;
      cfg_r.glyph_width  <= GLYPH_WIDTH_RST;
      cfg_r.glyph_height <= GLYPH_HEIGHT_RST;
      cfg_r.wrap_enable  <= WRAP_ENABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A request is taken whenever the skid register is free.
  assign in_ch.ready = room;
  assign fire        = in_ch.valid && room;

  assign req.command   = in_ch.command;
  assign req.start_x   = in_ch.start_x;
  assign req.start_y   = in_ch.start_y;
  assign req.text_byte = in_ch.text_byte;

  utc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .cfg   (cfg_r),
    .push  (push)
  );

  utc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .room      (room)
  );

  assign out_ch.kind       = out_item.kind;
  assign out_ch.code_point = out_item.code_point;
  assign out_ch.pos_x      = out_item.pos_x;
  assign out_ch.pos_y      = out_item.pos_y;

  // Terms shared by the checks below.
  assign end_out    = out_ch.valid && (out_item.kind == KIND_END);
  assign idle_begin = fire && (req.command == CMD_BEGIN) && !out_ch.valid;

  // The input only stalls when a result is already waiting at the output.
  `UTC_ASSERT_NOW(a_stall_needs_result, !in_ch.ready, out_ch.valid, "input stalled, no result")
  // An end report never carries a code point.
  `UTC_ASSERT_NOW(a_end_cp_zero, end_out, out_item.code_point == '0, "end report with code")
  // A begin request taken into an empty buffer produces no result.
  `UTC_ASSERT_NEXT(a_begin_silent, idle_begin, !out_ch.valid, "begin request gave a result")

endmodule

@@ design/utc_core.sv @@
// Decoder and cursor state: one request per cycle, result handed to the output buffer.
// Depends on utc_pkg. Requests are taken only while fire is high.
module utc_core import utc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  req,
  input  cfg_t      cfg,
  output res_push_t push
);

  logic [CodeW-1:0]  partial_r, partial_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [CoordW-1:0] cursor_x_r, cursor_x_nxt;
  logic [CoordW-1:0] cursor_y_r, cursor_y_nxt;
  logic [CoordW-1:0] origin_r, origin_nxt;

  logic [CodeW-1:0]  cont_code;
  logic              is_cont;
  logic [CoordW:0]   adv_sum;
  logic [CoordW-1:0] adv_x;
  logic [CoordW:0]   line_sum;
  logic [CoordW-1:0] line_y;
  logic              wrap_far;
  logic              place_en;
  logic [CodeW-1:0]  place_cp;
  logic              lead;
  logic [ByteW-1:0]  b;

  assign b         = req.text_byte;
  assign is_cont   = (b[7:6] == 2'b10);
  assign cont_code = {partial_r[CodeW-7:0], b[5:0]};

  // Advance with saturation, then the wrap test on the advanced column.
  assign adv_sum  = {1'b0, cursor_x_r} + {{(CoordW+1-GlyphW){1'b0}}, cfg.glyph_width}
                    + {{CoordW{1'b0}}, 1'b1};
  assign adv_x    = adv_sum[CoordW] ? {CoordW{1'b1}} : adv_sum[CoordW-1:0];
  assign wrap_far = cfg.wrap_enable &&
                    (({1'b0, adv_x} + {{(CoordW+1-GlyphW){1'b0}}, cfg.glyph_width})
                     > {1'b0, cfg.disp_width});
  assign line_sum = {1'b0, cursor_y_r} + {{(CoordW+1-GlyphW){1'b0}}, cfg.glyph_height};
  assign line_y   = line_sum[CoordW] ? {CoordW{1'b1}} : line_sum[CoordW-1:0];

  always_comb begin
    partial_nxt  = partial_r;
    pend_nxt     = pend_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    origin_nxt   = origin_r;
    place_en     = 1'b0;
    place_cp     = '0;
    lead         = 1'b1;
    push         = '0;
    push.item.pos_x = cursor_x_r;
    push.item.pos_y = cursor_y_r;

    if (req.command == CMD_BEGIN) begin
      cursor_x_nxt = req.start_x;
      origin_nxt   = req.start_x;
      cursor_y_nxt = req.start_y;
      partial_nxt  = '0;
      pend_nxt     = '0;
      lead         = 1'b0;
    end else if (pend_r != 2'd0) begin
      if (is_cont) begin
        lead        = 1'b0;
        partial_nxt = cont_code;
        pend_nxt    = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          place_en = 1'b1;
          place_cp = cont_code;
        end
      end else begin
        // Broken sequence: drop it and take this byte as a fresh lead.
        partial_nxt = '0;
        pend_nxt    = '0;
      end
    end

    if (lead) begin
      if (b == '0) begin
        push.valid     = 1'b1;
        push.item.kind = KIND_END;
      end else if (!b[7]) begin
        place_en = 1'b1;
        place_cp = {{(CodeW-ByteW){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        partial_nxt = {{(CodeW-5){1'b0}}, b[4:0]};
        pend_nxt    = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        partial_nxt = {{(CodeW-4){1'b0}}, b[3:0]};
        pend_nxt    = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        partial_nxt = {{(CodeW-3){1'b0}}, b[2:0]};
        pend_nxt    = 2'd3;
      end
    end

    if (place_en) begin
      push.valid           = 1'b1;
      push.item.kind       = KIND_GLYPH;
      push.item.code_point = place_cp;
      if (wrap_far && (place_cp == SPACE_CP)) begin
        cursor_x_nxt = origin_r;
        cursor_y_nxt = line_y;
      end else begin
        cursor_x_nxt = adv_x;
      end
    end

    push.valid = push.valid && fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r  <= '0;
      pend_r     <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      origin_r   <= '0;
    end else if (fire) begin
      partial_r  <= partial_nxt;
      pend_r     <= pend_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      origin_r   <= origin_nxt;
    end
  end

endmodule

@@ design/utc_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on utc_pkg.
module utc_out_buf import utc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  input  logic      out_ready,
  output logic      out_valid,
  output res_item_t out_item,
  output logic      room
);

  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  res_item_t main_r, main_nxt;
  res_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_vld_r && out_ready;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;
  assign room      = !skid_vld_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (push.valid) begin
        main_nxt = push.item;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_vld_r) begin
        main_nxt     = push.item;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push.item;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
